/* rtl/crrt_pkg.sv */
`default_nettype none

package crrt_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int STAGE_IDX_W = 3;
    localparam int SLOT_IDX_W = 4;
    localparam int COUNT_W = 4;
    localparam int HITS_W = 8;

    // register index taken from paddr[2]
    localparam logic REG_STAGE_COUNT = 1'b0;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

`default_nettype wire

/* rtl/chained_range_remap_table.sv */
`default_nettype none

// Range remap table: NUM_STAGES stages of WINDOWS_PER_STAGE windows. A write
// word stores one window and is acknowledged in the cycle after start; busy
// stays low. A lookup word walks stages 0..N-1, N = stage_count saturated
// at NUM_STAGES; busy is high during the walk; done strobes after the last
// stage (the cycle after start if N is zero). One stage row is read
// from the window memory per cycle and all its windows are compared at once
// in the shared stage unit. Results show for a single cycle on done and
// cannot be stalled. Window valid bits clear at reset; no clearing pass.
module chained_range_remap_table
    import crrt_pkg::*;
#(
    parameter int NUM_STAGES = 8,
    parameter int WINDOWS_PER_STAGE = 16,
    parameter int VALUE_WIDTH = 40
)
(
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic start,
    output logic busy,
    input  wire logic operation,
    input  wire logic [STAGE_IDX_W-1:0] stage_index,
    input  wire logic [SLOT_IDX_W-1:0] slot_index,
    input  wire logic entry_valid,
    input  wire logic [VALUE_WIDTH-1:0] src_base,
    input  wire logic [VALUE_WIDTH-1:0] dst_base,
    input  wire logic [VALUE_WIDTH-1:0] range_length,
    input  wire logic [VALUE_WIDTH-1:0] lookup_value,

    output logic done,
    output logic [VALUE_WIDTH-1:0] mapped_value,
    output logic [HITS_W-1:0] stage_hits,
    output logic was_write,

    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic pready
);

    localparam int VW = VALUE_WIDTH;
    localparam int WPS = WINDOWS_PER_STAGE;
    localparam int STAGE_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int SLOT_W = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int CNT_W = $clog2(NUM_STAGES + 1);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] stage_count_reg;

    logic [CNT_W-1:0] stage_reg, stage_next;
    logic [CNT_W-1:0] last_reg, last_next;
    logic [VW-1:0] value_reg, value_next;
    logic [HITS_W-1:0] hits_reg, hits_next;

    logic done_reg, done_next;
    logic [VW-1:0] out_value_reg, out_value_next;
    logic [HITS_W-1:0] out_hits_reg, out_hits_next;
    logic out_write_reg, out_write_next;

    logic [WPS-1:0] valid_reg [NUM_STAGES];
    logic [VW-1:0] mem_start [NUM_STAGES][WPS];
    logic [VW:0] mem_bound [NUM_STAGES][WPS];
    logic [VW-1:0] mem_delta [NUM_STAGES][WPS];

    logic [WPS-1:0] row_valid_reg;
    logic [VW-1:0] row_start_reg [WPS];
    logic [VW:0] row_bound_reg [WPS];
    logic [VW-1:0] row_delta_reg [WPS];

    logic accept;
    logic wr_en;
    logic [7:0] wr_stage_ext;
    logic [7:0] wr_slot_ext;
    logic [STAGE_W-1:0] wr_row;
    logic [SLOT_W-1:0] wr_slot;
    logic [STAGE_W-1:0] rd_row;
    logic [CNT_W-1:0] stage_inc;
    logic [CNT_W-1:0] count_eff;
    logic is_last;
    logic cfg_wr;

    logic [VW-1:0] unit_value;
    logic unit_hit;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_STAGE_COUNT);
    assign prdata = (paddr[2] == REG_STAGE_COUNT) ? PDATA_W'(stage_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            stage_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign busy = (state_reg == ST_RUN);
    assign accept = start && !busy;

    always_comb
    begin
        if (5'(stage_count_reg) > 5'(NUM_STAGES))
        begin
            count_eff = CNT_W'(NUM_STAGES);
        end
        else
        begin
            count_eff = CNT_W'(stage_count_reg);
        end
    end

    // window writes: bound and delta are formed on the way in
    assign wr_stage_ext = 8'(stage_index);
    assign wr_slot_ext = 8'(slot_index);
    assign wr_row = wr_stage_ext[STAGE_W-1:0];
    assign wr_slot = wr_slot_ext[SLOT_W-1:0];
    assign wr_en = accept && (op_t'(operation) == OP_WRITE)
                   && (wr_stage_ext < 8'(NUM_STAGES)) && (wr_slot_ext < 8'(WPS));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_row][wr_slot] <= src_base;
            mem_bound[wr_row][wr_slot] <= {1'b0, src_base} + {1'b0, range_length};
            mem_delta[wr_row][wr_slot] <= dst_base - src_base;
        end
        row_start_reg <= mem_start[rd_row];
        row_bound_reg <= mem_bound[rd_row];
        row_delta_reg <= mem_delta[rd_row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                valid_reg[s] <= '0;
            end
            row_valid_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_row][wr_slot] <= entry_valid;
            end
            row_valid_reg <= valid_reg[rd_row];
        end
    end

    // prefetch next stage row while the current one is evaluated
    assign stage_inc = stage_reg + 1'b1;
    assign is_last = (stage_reg == last_reg);
    assign rd_row = (busy && !is_last) ? stage_inc[STAGE_W-1:0] : '0;

    crrt_stage_unit
    #(
        .WINDOWS (WPS),
        .VW      (VW)
    )
    u_stage
    (
        .value_in  (value_reg),
        .row_valid (row_valid_reg),
        .row_start (row_start_reg),
        .row_bound (row_bound_reg),
        .row_delta (row_delta_reg),
        .value_out (unit_value),
        .hit       (unit_hit)
    );

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        last_next = last_reg;
        value_next = value_reg;
        hits_next = hits_reg;
        done_next = 1'b0;
        out_value_next = out_value_reg;
        out_hits_next = out_hits_reg;
        out_write_next = out_write_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(operation) == OP_WRITE)
                    begin
                        done_next = 1'b1;
                        out_value_next = '0;
                        out_hits_next = '0;
                        out_write_next = 1'b1;
                    end
                    else if (count_eff == '0)
                    begin
                        done_next = 1'b1;
                        out_value_next = lookup_value;
                        out_hits_next = '0;
                        out_write_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        stage_next = '0;
                        last_next = count_eff - 1'b1;
                        value_next = lookup_value;
                        hits_next = '0;
                    end
                end
            end
            ST_RUN:
            begin
                value_next = unit_value;
                for (int i = 0; i < HITS_W; i++)
                begin
                    hits_next[i] = hits_reg[i] || (unit_hit && (int'(stage_reg) == i));
                end
                if (is_last)
                begin
                    state_next = ST_IDLE;
                    done_next = 1'b1;
                    out_value_next = unit_value;
                    out_hits_next = hits_next;
                    out_write_next = 1'b0;
                end
                else
                begin
                    stage_next = stage_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stage_reg <= '0;
            last_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        hits_reg <= hits_next;
        out_value_reg <= out_value_next;
        out_hits_reg <= out_hits_next;
        out_write_reg <= out_write_next;
    end

    assign done = done_reg;
    assign mapped_value = out_value_reg;
    assign stage_hits = out_hits_reg;
    assign was_write = out_write_reg;

    a_last_stage_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && is_last) |=> (done && !busy && !was_write))
        else $error("lookup did not finish after its last stage");

    a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_WRITE) |=>
        (done && was_write && mapped_value == '0 && stage_hits == '0))
        else $error("write not acknowledged");

    a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (stage_reg <= last_reg && last_reg < CNT_W'(NUM_STAGES)))
        else $error("stage counter beyond lookup length");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while lookup in progress");

endmodule

`default_nettype wire

/* rtl/crrt_stage_unit.sv */
`default_nettype none

module crrt_stage_unit
#(
    parameter int WINDOWS = 16,
    parameter int VW = 40
)
(
    input  wire logic [VW-1:0] value_in,
    input  wire logic [WINDOWS-1:0] row_valid,
    input  wire logic [VW-1:0] row_start [WINDOWS],
    input  wire logic [VW:0] row_bound [WINDOWS],
    input  wire logic [VW-1:0] row_delta [WINDOWS],
    output logic [VW-1:0] value_out,
    output logic hit
);

    logic [WINDOWS-1:0] match;
    logic [VW-1:0] sel_delta;

    always_comb
    begin
        for (int i = 0; i < WINDOWS; i++)
        begin
            match[i] = row_valid[i] && (value_in >= row_start[i])
                       && ({1'b0, value_in} < row_bound[i]);
        end
    end

    // lowest matching slot wins
    always_comb
    begin
        sel_delta = '0;
        for (int i = WINDOWS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                sel_delta = row_delta[i];
            end
        end
    end

    assign hit = |match;
    assign value_out = hit ? (value_in + sel_delta) : value_in;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench
    import crrt_pkg::*;
();

    localparam int N_STAGES = 8;
    localparam int N_SLOTS = 16;
    localparam int N_WINDOWS = N_STAGES * N_SLOTS;
    localparam int VW = 40;
    localparam int N_PHASES = 8;
    localparam int PHASE_WORDS = 230;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        op_t op;
        logic [STAGE_IDX_W-1:0] stage;
        logic [SLOT_IDX_W-1:0] slot;
        logic ev;
        logic [VW-1:0] src;
        logic [VW-1:0] dst;
        logic [VW-1:0] len;
        logic [VW-1:0] look;
    } remap_word_t;

    typedef struct {
        logic [VW-1:0] mapped;
        logic [HITS_W-1:0] hits;
        logic was_write;
    } remap_result_t;

    class remap_scoreboard;
        logic [VW-1:0] src_tab [N_WINDOWS];
        logic [VW-1:0] dst_tab [N_WINDOWS];
        logic [VW-1:0] len_tab [N_WINDOWS];
        bit valid_tab [N_WINDOWS];
        logic [COUNT_W-1:0] stage_count;
        remap_result_t expected_q [$];
        int mismatches;
        int checked;
        int writes;
        int lookups;
        int hit_lookups;

        function new();
            foreach (valid_tab[i])
            begin
                valid_tab[i] = 1'b0;
                src_tab[i] = '0;
                dst_tab[i] = '0;
                len_tab[i] = '0;
            end
            stage_count = '0;
            mismatches = 0;
            checked = 0;
            writes = 0;
            lookups = 0;
            hit_lookups = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // translate at acceptance; table and stage_count as of this word
        function void note_word(op_t op, logic [STAGE_IDX_W-1:0] stage,
                                logic [SLOT_IDX_W-1:0] slot, logic ev,
                                logic [VW-1:0] src, logic [VW-1:0] dst,
                                logic [VW-1:0] len, logic [VW-1:0] look);
            remap_result_t r;
            logic [VW-1:0] value;
            logic [VW:0] bound;
            int count;
            int idx;
            bit hit;
            r.mapped = '0;
            r.hits = '0;
            r.was_write = 1'b0;
            if (op == OP_WRITE)
            begin
                idx = int'(stage) * N_SLOTS + int'(slot);
                valid_tab[idx] = ev;
                src_tab[idx] = src;
                dst_tab[idx] = dst;
                len_tab[idx] = len;
                r.was_write = 1'b1;
                writes++;
            end
            else
            begin
                value = look;
                count = (int'(stage_count) > N_STAGES) ? N_STAGES : int'(stage_count);
                for (int s = 0; s < count; s++)
                begin
                    hit = 1'b0;
                    for (int k = 0; k < N_SLOTS && !hit; k++)
                    begin
                        idx = s * N_SLOTS + k;
                        bound = {1'b0, src_tab[idx]} + {1'b0, len_tab[idx]};
                        if (valid_tab[idx] && value >= src_tab[idx] && {1'b0, value} < bound)
                        begin
                            value = dst_tab[idx] + (value - src_tab[idx]);
                            hit = 1'b1;
                        end
                    end
                    if (hit && s < HITS_W)
                        r.hits[s] = 1'b1;
                end
                r.mapped = value;
                lookups++;
                if (r.hits != '0)
                    hit_lookups++;
            end
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(logic [VW-1:0] mapped, logic [HITS_W-1:0] hits,
                                   logic was_write);
            remap_result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: mapped=%h hits=%b write=%b",
                             mapped, hits, was_write);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (mapped !== e.mapped || hits !== e.hits || was_write !== e.was_write)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected mapped=%h hits=%b write=%b, ",
                              "got mapped=%h hits=%b write=%b"},
                             e.mapped, e.hits, e.was_write, mapped, hits, was_write);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic operation;
    logic [STAGE_IDX_W-1:0] stage_index;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic entry_valid;
    logic [VW-1:0] src_base;
    logic [VW-1:0] dst_base;
    logic [VW-1:0] range_length;
    logic [VW-1:0] lookup_value;
    logic done;
    logic [VW-1:0] mapped_value;
    logic [HITS_W-1:0] stage_hits;
    logic was_write;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    remap_scoreboard sb;
    int cycle_count;
    logic [COUNT_W-1:0] phase_setting [N_PHASES] =
        '{4'd8, 4'd15, 4'd1, 4'd0, 4'd5, 4'd8, 4'd12, 4'd8};

    chained_range_remap_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .stage_index(stage_index),
        .slot_index(slot_index),
        .entry_valid(entry_valid),
        .src_base(src_base),
        .dst_base(dst_base),
        .range_length(range_length),
        .lookup_value(lookup_value),
        .done(done),
        .mapped_value(mapped_value),
        .stage_hits(stage_hits),
        .was_write(was_write),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, sb.pending());
            $display("chained_range_remap_table verification failed");
            $finish;
        end
    end

    // check before note so a spurious result never consumes a fresh word
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(mapped_value, stage_hits, was_write);
        if (rst_n && start && !busy)
            sb.note_word(op_t'(operation), stage_index, slot_index, entry_valid,
                         src_base, dst_base, range_length, lookup_value);
    end

    function automatic logic [VW-1:0] rand_value();
        return VW'({$urandom(), $urandom()});
    endfunction

    function automatic logic [VW-1:0] small_value();
        return VW'($urandom_range(0, 64));
    endfunction

    function automatic remap_word_t write_word(int stage, int slot, logic ev, logic [VW-1:0] src,
                                               logic [VW-1:0] dst, logic [VW-1:0] len);
        remap_word_t w;
        w.op = OP_WRITE;
        w.stage = STAGE_IDX_W'(stage);
        w.slot = SLOT_IDX_W'(slot);
        w.ev = ev;
        w.src = src;
        w.dst = dst;
        w.len = len;
        w.look = rand_value();
        return w;
    endfunction

    function automatic remap_word_t lookup_word(logic [VW-1:0] value);
        remap_word_t w;
        w = write_word(int'($urandom_range(0, 7)), int'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)), rand_value(), rand_value(), rand_value());
        w.op = OP_LOOKUP;
        w.look = value;
        return w;
    endfunction

    // a value inside some valid window of the stage, when one is found quickly
    function automatic logic [VW-1:0] window_value(int stage);
        int idx;
        logic [VW-1:0] off;
        for (int t = 0; t < 8; t++)
        begin
            idx = stage * N_SLOTS + int'($urandom_range(0, N_SLOTS - 1));
            if (sb.valid_tab[idx] && sb.len_tab[idx] != '0)
            begin
                case ($urandom_range(0, 3))
                    0: off = '0;
                    1: off = sb.len_tab[idx] - 1'b1;
                    default: off = rand_value() % sb.len_tab[idx];
                endcase
                return sb.src_tab[idx] + off;
            end
        end
        return rand_value();
    endfunction

    function automatic remap_word_t random_word();
        remap_word_t w;
        int idx;
        logic [VW-1:0] len;
        logic [VW-1:0] src;
        logic [VW-1:0] dst;
        logic [VW-1:0] value;
        if ($urandom_range(0, 9) < 4)
        begin
            case ($urandom_range(0, 9))
                0: len = '0;
                1: len = '1;
                2: len = rand_value();
                default: len = VW'($urandom_range(1, 1 << (4 * $urandom_range(1, 6))));
            endcase
            w = write_word(int'($urandom_range(0, 7)), int'($urandom_range(0, 15)),
                           1'($urandom_range(0, 7) != 0), '0, '0, len);
            case ($urandom_range(0, 5))
                0: src = rand_value();
                1: src = '1 - small_value();
                2: src = small_value();
                default:
                begin
                    // chain onto a destination of the previous stage
                    if (w.stage != '0)
                    begin
                        idx = (int'(w.stage) - 1) * N_SLOTS + int'($urandom_range(0, N_SLOTS - 1));
                        src = sb.dst_tab[idx] - small_value();
                    end
                    else
                        src = rand_value();
                end
            endcase
            case ($urandom_range(0, 3))
                0: dst = '1 - small_value();
                1: dst = small_value();
                default: dst = rand_value();
            endcase
            w.src = src;
            w.dst = dst;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1: value = rand_value();
                2:
                begin
                    idx = int'($urandom_range(0, N_WINDOWS - 1));
                    if ($urandom_range(0, 1) == 0)
                        value = sb.src_tab[idx] + sb.len_tab[idx];
                    else
                        value = sb.src_tab[idx] - 1'b1;
                end
                3: value = ($urandom_range(0, 1) == 0) ? '0 : '1;
                4, 5, 6: value = window_value(0);
                default: value = window_value(int'($urandom_range(0, N_STAGES - 1)));
            endcase
            w = lookup_word(value);
        end
        return w;
    endfunction

    task automatic send_word(input remap_word_t w);
        @(negedge clk);
        start <= 1'b1;
        operation <= w.op;
        stage_index <= w.stage;
        slot_index <= w.slot;
        entry_valid <= w.ev;
        src_base <= w.src;
        dst_base <= w.dst;
        range_length <= w.len;
        lookup_value <= w.look;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);
    endtask

    task automatic write_stage_count(input logic [COUNT_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_STAGE_COUNT, 2'b00};
        pwdata <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.stage_count = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operation = 1'b0;
        stage_index = '0;
        slot_index = '0;
        entry_valid = 1'b0;
        src_base = '0;
        dst_base = '0;
        range_length = '0;
        lookup_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        phase_setting[4] = COUNT_W'($urandom_range(2, 7));

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no stages: values pass unchanged
        send_word(lookup_word('0));
        send_word(lookup_word('1));
        wait_drained();
        write_stage_count(4'd8);

        send_word(write_word(0, 0, 1'b1, '0, '1, 40'd1));
        send_word(write_word(0, 1, 1'b1, '0, 40'd100, '1));
        send_word(write_word(1, 15, 1'b1, '1, '0, '1));
        send_word(write_word(2, 3, 1'b0, '0, 40'd5, '1));
        send_word(write_word(3, 2, 1'b1, 40'd10, 40'd20, '0));
        send_word(write_word(7, 15, 1'b1, '0, '1, '1));
        send_word(lookup_word('0));
        send_word(lookup_word(40'd1));
        send_word(lookup_word('1));
        send_word(lookup_word(40'd10));
        send_word(lookup_word(40'h12_3456_789A));
        // disabling the top-priority window exposes the next slot
        send_word(write_word(0, 0, 1'b0, '0, '1, 40'd1));
        send_word(lookup_word('0));
        wait_drained();
        write_stage_count(4'd15);
        send_word(lookup_word('0));
        send_word(lookup_word(40'd1));
        send_word(lookup_word('1));
        wait_drained();
        write_stage_count(4'd1);
        send_word(lookup_word(40'd5));
        send_word(lookup_word('0));

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_drained();
            write_stage_count(phase_setting[p]);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (p != N_PHASES - 1 && $urandom_range(0, 4) == 0)
                    idle_cycles(int'($urandom_range(1, 16)));
                send_word(random_word());
            end
        end

        wait_drained();
        $display("covered %0d window writes and %0d lookups, %0d of them hitting a window",
                 sb.writes, sb.lookups, sb.hit_lookups);
        $display("stage_count swept over 0, 1, 8, 15 and mid values; %0d checked, %0d mismatches",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("chained_range_remap_table verification clean");
        else
            $display("chained_range_remap_table verification failed");
        $finish;
    end

endmodule

/* chained_range_remap_table.f */
rtl/crrt_pkg.sv
rtl/crrt_stage_unit.sv
rtl/chained_range_remap_table.sv
dv/testbench.sv
